>>> rtl/cxbc_pkg.sv
// ============================================================================
// Chained XOR byte cipher package
// Shared types, constants and the key table for the cipher block.
// ============================================================================
package cxbc_pkg;

    // Running sum value at the start of every message.
    localparam logic [7:0] SUM_START = 8'h80;

    // Number of bytes in the key table.
    localparam int KEY_LEN = 14;

    // Last valid key position.
    localparam logic [3:0] KEY_POS_LAST = 4'(KEY_LEN - 1);

    // Register indexes on the configuration port.
    typedef enum logic
    {
        REG_DIRECTION  = 1'b0,
        REG_MARK_VALUE = 1'b1
    } reg_index_t;

    // Cipher direction codes.
    typedef enum logic
    {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } direction_t;

    // One input transfer.
    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    // One result transfer.
    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       out_last;
        logic       is_mark;
        logic       mark_error;
    } out_item_t;

    // Configuration seen by the cipher engine.
    typedef struct packed
    {
        direction_t direction;
        logic [7:0] mark_value;
    } cfg_t;

    // Results produced by the engine for one accepted item.
    typedef struct packed
    {
        logic      dual;
        out_item_t lead_item;
        out_item_t tail_item;
    } eng_res_t;

    // Key table lookup; positions past the end read as position zero.
    function automatic logic [7:0] key_byte(input logic [3:0] pos);
        logic [7:0] k;
        begin
            case (pos)
                4'd1:    k = 8'h6C; // l
                4'd2:    k = 8'h71; // q
                4'd3:    k = 8'h64; // d
                4'd4:    k = 8'h70; // p
                4'd5:    k = 8'h72; // r
                4'd6:    k = 8'h6B; // k
                4'd7:    k = 8'h72; // r
                4'd8:    k = 8'h68; // h
                4'd9:    k = 8'h74; // t
                4'd10:   k = 8'h6C; // l
                4'd11:   k = 8'h76; // v
                4'd12:   k = 8'h65; // e
                4'd13:   k = 8'h6B; // k
                default: k = 8'h77; // w
            endcase
            return k;
        end
    endfunction

    // Advance the key position with wrap; out-of-range positions act as zero.
    function automatic logic [3:0] next_pos(input logic [3:0] pos);
        logic [3:0] n;
        begin
            if (pos >= KEY_POS_LAST)
            begin
                n = (pos == KEY_POS_LAST) ? 4'd0 : 4'd1;
            end
            else
            begin
                n = pos + 4'd1;
            end
            return n;
        end
    endfunction

endpackage

>>> rtl/cxbc_engine.sv
// ============================================================================
// Chained XOR byte cipher engine
// Holds the running sum and key position and computes the results of one
// accepted byte in a single pass.
// ============================================================================
module cxbc_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  cxbc_pkg::in_item_t item,
    input  cxbc_pkg::cfg_t     cfg,
    output cxbc_pkg::eng_res_t res
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;

    logic [7:0] sum_base;
    logic [3:0] pos_base;
    logic [3:0] pos_one;
    logic [7:0] key_a;
    logic [7:0] key_b;
    logic [7:0] enc_sum_a;
    logic [7:0] enc_sum_b;
    logic [7:0] dec_xor;
    logic [7:0] dec_plain;

    // A new message restarts the chain.
    assign sum_base = item.first_byte ? cxbc_pkg::SUM_START : sum_reg;
    assign pos_base = item.first_byte ? 4'd0 : pos_reg;
    assign pos_one  = cxbc_pkg::next_pos(pos_base);
    assign key_a    = cxbc_pkg::key_byte(pos_base);
    assign key_b    = cxbc_pkg::key_byte(pos_one);

    // Encrypt: on a first byte the mark goes through the chain ahead of the data.
    assign enc_sum_a = sum_base + (item.first_byte ? cfg.mark_value : item.data_byte);
    assign enc_sum_b = enc_sum_a + item.data_byte;

    // Decrypt: the new sum is simply the unkeyed ciphertext.
    assign dec_xor   = item.data_byte ^ key_a;
    assign dec_plain = dec_xor - sum_base;

    // Result selection and next state.
    always_comb
    begin
        res = '0;
        sum_next = sum_reg;
        pos_next = pos_reg;
        if (cfg.direction == cxbc_pkg::DIR_DECRYPT)
        begin
            res.dual                 = 1'b0;
            res.lead_item.out_byte   = dec_plain;
            res.lead_item.out_last   = item.last_byte;
            res.lead_item.is_mark    = item.first_byte;
            res.lead_item.mark_error = item.first_byte && (dec_plain != cfg.mark_value);
            sum_next = dec_xor;
            pos_next = pos_one;
        end
        else if (item.first_byte)
        begin
            res.dual                 = 1'b1;
            res.lead_item.out_byte   = enc_sum_a ^ key_a;
            res.lead_item.is_mark    = 1'b1;
            res.tail_item.out_byte   = enc_sum_b ^ key_b;
            res.tail_item.out_last   = item.last_byte;
            sum_next = enc_sum_b;
            pos_next = cxbc_pkg::next_pos(pos_one);
        end
        else
        begin
            res.dual                 = 1'b0;
            res.lead_item.out_byte   = enc_sum_a ^ key_a;
            res.lead_item.out_last   = item.last_byte;
            sum_next = enc_sum_a;
            pos_next = pos_one;
        end
    end

    // Chain state advances only on an accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= cxbc_pkg::SUM_START;
            pos_reg <= 4'd0;
        end
        else if (accept)
        begin
            sum_reg <= sum_next;
            pos_reg <= pos_next;
        end
    end

endmodule

>>> rtl/chained_xor_byte_cipher.sv
// ============================================================================
// Chained XOR byte cipher
// Byte-stream cipher with a running sum and a fixed key table, with mark
// insertion on encrypt and mark checking on decrypt.
// ============================================================================
//
//   Channel   Signals                           Direction
//   -------   -------------------------------   ---------
//   input     in_valid, in_stall, in_data       into block
//   output    out_valid, out_stall, out_data    out of block
//   config    psel, penable, pwrite, paddr ...  APB slave
//
// A byte can be accepted every cycle while the input is not stalled; its
// result is registered into the output register. An encrypted first byte
// yields two transfers (mark, then data), which stalls the input while the
// second result waits in the pending register. The input also stalls while
// the output is stalled and full. Reset restores the sum to 0x80, position 0,
// and clears the valid flags of both result registers.
module chained_xor_byte_cipher
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cxbc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cxbc_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cxbc_pkg::cfg_t      cfg_reg;
    cxbc_pkg::eng_res_t  res;
    cxbc_pkg::out_item_t out_item_reg;
    cxbc_pkg::out_item_t pend_item_reg;
    logic                out_valid_reg;
    logic                pend_valid_reg;
    logic                accept;
    logic                out_take;
    logic                cfg_write;
    cxbc_pkg::reg_index_t cfg_sel;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cxbc_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction  <= cxbc_pkg::DIR_ENCRYPT;
            cfg_reg.mark_value <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                cxbc_pkg::REG_DIRECTION:  cfg_reg.direction  <= cxbc_pkg::direction_t'(pwdata[0]);
                cxbc_pkg::REG_MARK_VALUE: cfg_reg.mark_value <= pwdata[7:0];
                default:                  cfg_reg.mark_value <= cfg_reg.mark_value;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            cxbc_pkg::REG_DIRECTION:  prdata = {31'd0, cfg_reg.direction};
            cxbc_pkg::REG_MARK_VALUE: prdata = {24'd0, cfg_reg.mark_value};
            default:                  prdata = 32'd0;
        endcase
    end

    // Handshake: take a byte when both result slots can absorb it.
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = pend_valid_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    cxbc_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .res    (res)
    );

    // Output register with one pending slot for the second result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= res.dual;
        end
        else if (pend_valid_reg && (!out_valid_reg || out_take))
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg  <= 1'b0;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg  <= res.lead_item;
            pend_item_reg <= res.tail_item;
        end
        else if (pend_valid_reg && (!out_valid_reg || out_take))
        begin
            out_item_reg  <= pend_item_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

`ifndef SYNTHESIS
    // A pending result always sits behind a valid output.
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a valid output");

    // An accepted byte always presents a result in the next cycle.
    a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted byte produced no result");

    // The second result of a pair is the data byte, never the mark.
    a_pend_not_mark: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (!pend_item_reg.is_mark && !pend_item_reg.mark_error))
        else $error("pending result flagged as mark");
`endif

endmodule
